@@ hdl/ttc_pkg.sv @@
// Package for the triangle tangent calculator: widths, slot and component codes,
// request/result payload structs, sequencer states and inter-module control structs.
// No dependencies.
package ttc_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned DELTA_W = COORD_W + 1;
   localparam int unsigned PROD_W  = 2 * DELTA_W;
   localparam int unsigned ACC_W   = PROD_W + 1;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned QUOT_W  = 32;
   localparam int unsigned REM_W   = ACC_W + FRAC_W;
   localparam int unsigned DSH_W   = ACC_W + QUOT_W;
   localparam int unsigned STEP_W  = 6;
   localparam int unsigned NUM_COMP = 3;

   localparam logic [STEP_W-1:0] STEP_TOP = 6'd32;

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;

   localparam logic [1:0] COMP_X   = 2'd0;
   localparam logic [1:0] COMP_Z   = 2'd2;
   localparam logic [1:0] COMP_DET = 2'd3;

   localparam logic [QUOT_W-1:0] QUOT_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [QUOT_W-1:0] QUOT_NEG_MAX = 32'h8000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] tex_u;
      logic signed [COORD_W-1:0] tex_v;
   } vertex_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] tangent_x;
      logic signed [COORD_W-1:0] tangent_y;
      logic signed [COORD_W-1:0] tangent_z;
      logic                      degenerate;
      logic                      saturated;
   } tangent_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIFF,
      ST_DET_CHK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_sub;
   } mac_ctl_type;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic saturated;
   } div_stat_type;

endpackage

@@ hdl/ttc_stream_if.sv @@
// Valid/ready stream interface carrying one payload per request.
// Payload type is a parameter; no dependencies.
interface ttc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/ttc_mac.sv @@
// Shared multiply-accumulate unit: registered 33x33 signed product, then a
// 67-bit accumulator that loads or subtracts it. Depends on ttc_pkg.
module ttc_mac (
   input  logic                              clock,
   input  ttc_pkg::mac_ctl_type              ctl,
   input  logic signed [ttc_pkg::DELTA_W-1:0] a,
   input  logic signed [ttc_pkg::DELTA_W-1:0] b,
   output logic signed [ttc_pkg::ACC_W-1:0]   acc
);

   logic signed [ttc_pkg::PROD_W-1:0] prod_ff;
   logic signed [ttc_pkg::ACC_W-1:0]  acc_ff;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= a * b;
      end
      if (ctl.acc_load) begin
         acc_ff <= {prod_ff[ttc_pkg::PROD_W-1], prod_ff};
      end else if (ctl.acc_sub) begin
         acc_ff <= acc_ff - {prod_ff[ttc_pkg::PROD_W-1], prod_ff};
      end
   end

   assign acc = acc_ff;

endmodule

@@ hdl/ttc_div.sv @@
// Iterative restoring divider: (num << 16) / den on magnitudes, one quotient bit
// per cycle after an overflow check, with signed saturation. Depends on ttc_pkg.
module ttc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  ttc_pkg::div_ctl_type            ctl,
   input  logic [ttc_pkg::ACC_W-1:0]       num_mag,
   input  logic [ttc_pkg::ACC_W-1:0]       den_mag,
   output ttc_pkg::div_stat_type           stat,
   output logic [ttc_pkg::QUOT_W-1:0]      quot
);

   logic [ttc_pkg::REM_W-1:0]  rem_ff;
   logic [ttc_pkg::DSH_W-1:0]  dsh_ff;
   logic [ttc_pkg::QUOT_W-1:0] q_ff;
   logic [ttc_pkg::STEP_W-1:0] step_ff;
   logic                       busy_ff;
   logic                       fin_ff;
   logic                       ovf_ff;
   logic                       neg_ff;
   logic                       ge;
   logic                       sat;
   logic [ttc_pkg::QUOT_W-1:0] limit;

   assign ge = {{(ttc_pkg::DSH_W - ttc_pkg::REM_W){1'b0}}, rem_ff} >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         fin_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if ((step_ff == ttc_pkg::STEP_TOP && ge) || step_ff == '0) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff  <= {num_mag, {ttc_pkg::FRAC_W{1'b0}}};
         dsh_ff  <= {den_mag, {ttc_pkg::QUOT_W{1'b0}}};
         q_ff    <= '0;
         step_ff <= ttc_pkg::STEP_TOP;
         ovf_ff  <= 1'b0;
         neg_ff  <= ctl.neg;
      end else if (busy_ff) begin
         if (step_ff == ttc_pkg::STEP_TOP) begin
            ovf_ff <= ge;
         end else begin
            q_ff <= {q_ff[ttc_pkg::QUOT_W-2:0], ge};
            if (ge) begin
               rem_ff <= rem_ff - dsh_ff[ttc_pkg::REM_W-1:0];
            end
         end
         dsh_ff  <= dsh_ff >> 1;
         step_ff <= step_ff - 6'd1;
      end
   end

   always_comb begin
      limit = neg_ff ? ttc_pkg::QUOT_NEG_MAX : ttc_pkg::QUOT_POS_MAX;
      sat   = ovf_ff || (q_ff > limit);
      if (sat) begin
         quot = limit;
      end else if (neg_ff) begin
         quot = '0 - q_ff;
      end else begin
         quot = q_ff;
      end
      if (sat && neg_ff) begin
         quot = ttc_pkg::QUOT_NEG_MAX;
      end
   end

   assign stat.done      = fin_ff;
   assign stat.saturated = sat;

endmodule

@@ hdl/triangle_tangent_calc.sv @@
// Triangle tangent calculator, top level: vertex slots, sequencer, output register.
// The first two vertices of a triangle are taken in and give no result; the third starts
// the computation, which waits on the shared divider at one quotient bit per cycle for
// each component (ending early on overflow) and skips the divisions when degenerate.
// No vertex is accepted until the result is registered. Synchronous reset clears slot,
// sequencer and output valid; depends on ttc_pkg, ttc_stream_if, ttc_mac and ttc_div.
module triangle_tangent_calc (
   input logic           clock,
   input logic           reset,
   ttc_stream_if.sink    req,
   ttc_stream_if.source  rsp
);

   ttc_pkg::seq_state_type state_ff, state_in;

   logic [1:0] slot_ff;
   logic [1:0] comp_ff;

   logic signed [ttc_pkg::COORD_W-1:0] pos0_ff [ttc_pkg::NUM_COMP];
   logic signed [ttc_pkg::COORD_W-1:0] pos1_ff [ttc_pkg::NUM_COMP];
   logic signed [ttc_pkg::COORD_W-1:0] in_pos  [ttc_pkg::NUM_COMP];
   logic signed [ttc_pkg::COORD_W-1:0] tex0_u_ff, tex0_v_ff, tex1_u_ff, tex1_v_ff;

   logic signed [ttc_pkg::DELTA_W-1:0] dt0u_ff, dt0v_ff, dt1u_ff, dt1v_ff;
   logic signed [ttc_pkg::DELTA_W-1:0] dv0_ff [ttc_pkg::NUM_COMP];
   logic signed [ttc_pkg::DELTA_W-1:0] dv1_ff [ttc_pkg::NUM_COMP];

   logic [ttc_pkg::ACC_W-1:0]          det_mag_ff;
   logic                               det_neg_ff;
   logic signed [ttc_pkg::COORD_W-1:0] tan_ff [ttc_pkg::NUM_COMP];
   logic                               sat_acc_ff;
   logic                               degen_ff;

   logic                 rsp_valid_ff;
   ttc_pkg::tangent_type rsp_data_ff;

   logic                               req_accept;
   logic                               rsp_free;
   logic                               det_phase;
   logic                               acc_zero;
   ttc_pkg::mac_ctl_type               mac_ctl;
   logic signed [ttc_pkg::DELTA_W-1:0] mac_a, mac_b;
   logic signed [ttc_pkg::ACC_W-1:0]   mac_acc;
   logic [ttc_pkg::ACC_W-1:0]          acc_mag;
   ttc_pkg::div_ctl_type               div_ctl;
   ttc_pkg::div_stat_type              div_stat;
   logic [ttc_pkg::QUOT_W-1:0]         div_quot;

   function automatic logic signed [ttc_pkg::DELTA_W-1:0] coord_diff(
      input logic signed [ttc_pkg::COORD_W-1:0] a,
      input logic signed [ttc_pkg::COORD_W-1:0] b
   );
      coord_diff = {a[ttc_pkg::COORD_W-1], a} - {b[ttc_pkg::COORD_W-1], b};
   endfunction

   assign in_pos[0] = req.payload.pos_x;
   assign in_pos[1] = req.payload.pos_y;
   assign in_pos[2] = req.payload.pos_z;

   assign req_accept = req.valid && req.ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign det_phase  = comp_ff == ttc_pkg::COMP_DET;
   assign acc_zero   = mac_acc == '0;
   assign acc_mag    = mac_acc[ttc_pkg::ACC_W-1] ? ('0 - mac_acc) : mac_acc;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttc_pkg::ST_IDLE: begin
            if (req_accept && slot_ff == ttc_pkg::SLOT_THIRD) begin
               state_in = ttc_pkg::ST_MUL_A;
            end
         end
         ttc_pkg::ST_MUL_A: state_in = ttc_pkg::ST_MUL_B;
         ttc_pkg::ST_MUL_B: state_in = ttc_pkg::ST_DIFF;
         ttc_pkg::ST_DIFF: begin
            state_in = det_phase ? ttc_pkg::ST_DET_CHK : ttc_pkg::ST_DIV_START;
         end
         ttc_pkg::ST_DET_CHK: begin
            state_in = acc_zero ? ttc_pkg::ST_EMIT : ttc_pkg::ST_MUL_A;
         end
         ttc_pkg::ST_DIV_START: state_in = ttc_pkg::ST_DIV_WAIT;
         ttc_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = (comp_ff == ttc_pkg::COMP_Z) ? ttc_pkg::ST_EMIT : ttc_pkg::ST_MUL_A;
            end
         end
         ttc_pkg::ST_EMIT: begin
            if (rsp_free) begin
               state_in = ttc_pkg::ST_IDLE;
            end
         end
         default: state_in = ttc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req.ready        = 1'b0;
      mac_ctl.mul_en   = 1'b0;
      mac_ctl.acc_load = 1'b0;
      mac_ctl.acc_sub  = 1'b0;
      div_ctl.start    = 1'b0;
      div_ctl.neg      = mac_acc[ttc_pkg::ACC_W-1] ^ det_neg_ff;
      case (state_ff)
         ttc_pkg::ST_IDLE:      req.ready = 1'b1;
         ttc_pkg::ST_MUL_A:     mac_ctl.mul_en = 1'b1;
         ttc_pkg::ST_MUL_B: begin
            mac_ctl.mul_en   = 1'b1;
            mac_ctl.acc_load = 1'b1;
         end
         ttc_pkg::ST_DIFF:      mac_ctl.acc_sub = 1'b1;
         ttc_pkg::ST_DIV_START: div_ctl.start = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      if (state_ff == ttc_pkg::ST_MUL_A) begin
         mac_a = det_phase ? dt0u_ff : dv0_ff[comp_ff];
         mac_b = dt1v_ff;
      end else begin
         mac_a = det_phase ? dt0v_ff : dv1_ff[comp_ff];
         mac_b = det_phase ? dt1u_ff : dt0v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttc_pkg::ST_IDLE;
         slot_ff      <= ttc_pkg::SLOT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            case (slot_ff)
               ttc_pkg::SLOT_SECOND: slot_ff <= ttc_pkg::SLOT_THIRD;
               ttc_pkg::SLOT_THIRD:  slot_ff <= ttc_pkg::SLOT_FIRST;
               default:              slot_ff <= ttc_pkg::SLOT_SECOND;
            endcase
         end
         if (state_ff == ttc_pkg::ST_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold vertices, form deltas on the third
   always_ff @(posedge clock) begin
      if (req_accept) begin
         case (slot_ff)
            ttc_pkg::SLOT_SECOND: begin
               for (int c = 0; c < ttc_pkg::NUM_COMP; c++) begin
                  pos1_ff[c] <= in_pos[c];
               end
               tex1_u_ff <= req.payload.tex_u;
               tex1_v_ff <= req.payload.tex_v;
            end
            ttc_pkg::SLOT_THIRD: begin
               for (int c = 0; c < ttc_pkg::NUM_COMP; c++) begin
                  dv0_ff[c] <= coord_diff(pos1_ff[c], pos0_ff[c]);
                  dv1_ff[c] <= coord_diff(in_pos[c], pos0_ff[c]);
               end
               dt0u_ff <= coord_diff(tex1_u_ff, tex0_u_ff);
               dt0v_ff <= coord_diff(tex1_v_ff, tex0_v_ff);
               dt1u_ff <= coord_diff(req.payload.tex_u, tex0_u_ff);
               dt1v_ff <= coord_diff(req.payload.tex_v, tex0_v_ff);
            end
            default: begin
               for (int c = 0; c < ttc_pkg::NUM_COMP; c++) begin
                  pos0_ff[c] <= in_pos[c];
               end
               tex0_u_ff <= req.payload.tex_u;
               tex0_v_ff <= req.payload.tex_v;
            end
         endcase
      end
   end

   // advance through determinant and components
   always_ff @(posedge clock) begin
      case (state_ff)
         ttc_pkg::ST_IDLE: begin
            comp_ff <= ttc_pkg::COMP_DET;
         end
         ttc_pkg::ST_DET_CHK: begin
            comp_ff    <= ttc_pkg::COMP_X;
            det_mag_ff <= acc_mag;
            det_neg_ff <= mac_acc[ttc_pkg::ACC_W-1];
            degen_ff   <= acc_zero;
            sat_acc_ff <= 1'b0;
            for (int c = 0; c < ttc_pkg::NUM_COMP; c++) begin
               tan_ff[c] <= '0;
            end
         end
         ttc_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               tan_ff[comp_ff] <= div_quot;
               sat_acc_ff      <= sat_acc_ff | div_stat.saturated;
               comp_ff         <= comp_ff + 2'd1;
            end
         end
         ttc_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_data_ff.tangent_x  <= tan_ff[0];
               rsp_data_ff.tangent_y  <= tan_ff[1];
               rsp_data_ff.tangent_z  <= tan_ff[2];
               rsp_data_ff.degenerate <= degen_ff;
               rsp_data_ff.saturated  <= sat_acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   ttc_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (mac_acc)
   );

   ttc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .num_mag (acc_mag),
      .den_mag (det_mag_ff),
      .stat    (div_stat),
      .quot    (div_quot)
   );

endmodule
